>>> rtl/sde_pkg.sv
// ----------------------------------------------------------------------------
// sde_pkg
// Shared types and constants of the sortable deque engine.
// ----------------------------------------------------------------------------
package sde_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW     = $clog2(DEPTH + 1);
  localparam int CW     = LW + 1;

  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_DELETE     = 3'd4,
    REQ_SORT       = 3'd5,
    REQ_READ_ALL   = 3'd6,
    REQ_NONE       = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef logic [AW-1:0]            addr_t;
  typedef logic [LW-1:0]            len_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    addr_t raddr;
  } ram_req_t;

endpackage

>>> rtl/sde_req_if.sv
// ----------------------------------------------------------------------------
// sde_req_if
// Request channel: valid/ready handshake with request code and value.
// ----------------------------------------------------------------------------
interface sde_req_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           req_type;
  sde_pkg::data_t       value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

>>> rtl/sde_rsp_if.sv
// ----------------------------------------------------------------------------
// sde_rsp_if
// Result channel: valid/ready handshake with value, status, length and last.
// ----------------------------------------------------------------------------
interface sde_rsp_if;
  logic                 valid;
  logic                 ready;
  sde_pkg::data_t       value_out;
  logic [1:0]           status;
  sde_pkg::len_t        length;
  logic                 last;

  modport source (output valid, output value_out, output status, output length,
                  output last, input ready);
  modport sink   (input valid, input value_out, input status, input length,
                  input last, output ready);
endinterface

>>> rtl/sde_ram.sv
// ----------------------------------------------------------------------------
// sde_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sde_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32,
  parameter int AW_P    = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW_P-1:0]    waddr,
  input  logic [WIDTH_P-1:0] wdata,
  input  logic [AW_P-1:0]    raddr,
  output logic [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sde_ctrl.sv
// ----------------------------------------------------------------------------
// sde_ctrl
// Request sequencer: read-modify-write control of the value store and the
// sort scratch memory, plus the result output register.
// ----------------------------------------------------------------------------
module sde_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  sde_req_if.sink           in_ch,
  sde_rsp_if.source         out_ch,
  output sde_pkg::ram_req_t store_req,
  input  sde_pkg::data_t    store_rdata,
  output sde_pkg::ram_req_t tmp_req,
  input  sde_pkg::data_t    tmp_rdata
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_POP    = 8'b0000_0010,
    S_SRCH   = 8'b0000_0100,
    S_SHIFT  = 8'b0000_1000,
    S_SORT   = 8'b0001_0000,
    S_RDALL  = 8'b0010_0000,
    S_RDWAIT = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  sde_pkg::addr_t          front_r, front_nxt;
  sde_pkg::len_t           occ_r, occ_nxt;
  sde_pkg::data_t          val_r, val_nxt;
  logic [sde_pkg::CW-1:0]  cnt_r, cnt_nxt;
  logic [sde_pkg::CW-1:0]  pass_r, pass_nxt;
  sde_pkg::data_t          car_r, car_nxt;
  logic                    rv_r, rv_nxt;
  logic [sde_pkg::CW-1:0]  ri_r, ri_nxt;
  sde_pkg::data_t          res_val_r, res_val_nxt;
  sde_pkg::status_e        res_st_r, res_st_nxt;
  logic                    res_last_r, res_last_nxt;
  logic                    out_valid_r, out_valid_nxt;
  sde_pkg::data_t          out_val_r, out_val_nxt;
  sde_pkg::status_e        out_st_r, out_st_nxt;
  sde_pkg::len_t           out_len_r, out_len_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_fire;
  logic                    out_load;
  logic [sde_pkg::CW-1:0]  occ_w;
  logic [sde_pkg::CW-1:0]  passes;
  sde_pkg::data_t          d_sort;
  sde_pkg::addr_t          dst_idx;

  // logical position to physical address, front + i wraps at most once
  function automatic sde_pkg::addr_t slot(input sde_pkg::addr_t front,
                                          input logic [sde_pkg::CW-1:0] i);
    logic [sde_pkg::CW:0] sum;
    sum = (sde_pkg::CW + 1)'(front) + (sde_pkg::CW + 1)'(i);
    if (sum >= (sde_pkg::CW + 1)'(sde_pkg::DEPTH)) begin
      sum = sum - (sde_pkg::CW + 1)'(sde_pkg::DEPTH);
    end
    return sde_pkg::AW'(sum);
  endfunction

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_load     = (state_r == S_RESP) && (!out_valid_r || out_ch.ready);
  assign occ_w        = sde_pkg::CW'(occ_r);
  // even pass count so the last pass lands in the value store
  assign passes       = occ_r[0] ? occ_w + 1'b1 : occ_w;
  assign d_sort       = pass_r[0] ? tmp_rdata : store_rdata;
  assign dst_idx      = sde_pkg::AW'(ri_r - 1'b1);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_out = out_val_r;
  assign out_ch.status    = out_st_r;
  assign out_ch.length    = out_len_r;
  assign out_ch.last      = out_last_r;

  always_comb begin
    state_nxt    = state_r;
    front_nxt    = front_r;
    occ_nxt      = occ_r;
    val_nxt      = val_r;
    cnt_nxt      = cnt_r;
    pass_nxt     = pass_r;
    car_nxt      = car_r;
    rv_nxt       = 1'b0;
    ri_nxt       = ri_r;
    res_val_nxt  = res_val_r;
    res_st_nxt   = res_st_r;
    res_last_nxt = res_last_r;
    store_req    = '0;
    tmp_req      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt      = in_ch.value;
          res_val_nxt  = '0;
          res_st_nxt   = sde_pkg::ST_OK;
          res_last_nxt = 1'b1;
          cnt_nxt      = '0;
          pass_nxt     = '0;
          state_nxt    = S_RESP;
          case (sde_pkg::req_e'(in_ch.req_type))
            sde_pkg::REQ_PUSH_FRONT, sde_pkg::REQ_PUSH_BACK: begin
              if (occ_r >= sde_pkg::DEPTH_L) begin
                res_st_nxt = sde_pkg::ST_FULL;
              end else begin
                store_req.we    = 1'b1;
                store_req.wdata = in_ch.value;
                if (in_ch.req_type == sde_pkg::REQ_PUSH_FRONT) begin
                  front_nxt = (front_r == '0) ? sde_pkg::AW'(sde_pkg::DEPTH - 1)
                                              : front_r - 1'b1;
                  store_req.waddr = front_nxt;
                end else begin
                  store_req.waddr = slot(front_r, occ_w);
                end
                occ_nxt = occ_r + 1'b1;
              end
            end
            sde_pkg::REQ_POP_FRONT, sde_pkg::REQ_POP_BACK: begin
              if (occ_r == '0) begin
                res_st_nxt = sde_pkg::ST_EMPTY;
              end else begin
                if (in_ch.req_type == sde_pkg::REQ_POP_FRONT) begin
                  store_req.raddr = front_r;
                  front_nxt       = slot(front_r, sde_pkg::CW'(1));
                end else begin
                  store_req.raddr = slot(front_r, occ_w - 1'b1);
                end
                occ_nxt   = occ_r - 1'b1;
                state_nxt = S_POP;
              end
            end
            sde_pkg::REQ_DELETE: begin
              if (occ_r == '0) begin
                res_st_nxt = sde_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            sde_pkg::REQ_SORT: begin
              if (occ_r == '0) begin
                front_nxt = '0;
              end else begin
                state_nxt = S_SORT;
              end
            end
            sde_pkg::REQ_READ_ALL: begin
              if (occ_r == '0) begin
                res_st_nxt = sde_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_RDALL;
              end
            end
            default: ;
          endcase
        end
      end

      S_POP: begin
        res_val_nxt = store_rdata;
        state_nxt   = S_RESP;
      end

      S_SRCH: begin
        if (cnt_r < occ_w) begin
          store_req.raddr = slot(front_r, cnt_r);
          rv_nxt          = 1'b1;
          ri_nxt          = cnt_r;
          cnt_nxt         = cnt_r + 1'b1;
        end
        if (rv_r) begin
          if (store_rdata == val_r) begin
            res_val_nxt = store_rdata;
            cnt_nxt     = ri_r + 1'b1;
            rv_nxt      = 1'b0;
            state_nxt   = S_SHIFT;
          end else if (ri_r == occ_w - 1'b1) begin
            res_st_nxt = sde_pkg::ST_NOTFOUND;
            state_nxt  = S_RESP;
          end
        end
      end

      S_SHIFT: begin
        // close the gap: each value moves one place toward the front
        if (cnt_r < occ_w) begin
          store_req.raddr = slot(front_r, cnt_r);
          rv_nxt          = 1'b1;
          ri_nxt          = cnt_r;
          cnt_nxt         = cnt_r + 1'b1;
        end
        if (rv_r) begin
          store_req.we    = 1'b1;
          store_req.waddr = slot(front_r, ri_r - 1'b1);
          store_req.wdata = store_rdata;
        end
        if (cnt_r >= occ_w && !rv_r) begin
          occ_nxt   = occ_r - 1'b1;
          state_nxt = S_RESP;
        end
      end

      S_SORT: begin
        // one stable bubble pass per sweep, ping-ponging store and scratch
        if (cnt_r < occ_w) begin
          store_req.raddr = slot(front_r, cnt_r);
          tmp_req.raddr   = sde_pkg::AW'(cnt_r);
          rv_nxt          = 1'b1;
          ri_nxt          = cnt_r;
        end
        if (rv_r) begin
          if (ri_r == '0) begin
            car_nxt = d_sort;
          end else begin
            store_req.we    = pass_r[0];
            tmp_req.we      = !pass_r[0];
            store_req.waddr = dst_idx;
            tmp_req.waddr   = dst_idx;
            if (d_sort < car_r) begin
              store_req.wdata = d_sort;
              tmp_req.wdata   = d_sort;
            end else begin
              store_req.wdata = car_r;
              tmp_req.wdata   = car_r;
              car_nxt         = d_sort;
            end
          end
        end
        if (cnt_r == occ_w + 1'b1) begin
          store_req.we    = pass_r[0];
          tmp_req.we      = !pass_r[0];
          store_req.waddr = sde_pkg::AW'(occ_w - 1'b1);
          tmp_req.waddr   = sde_pkg::AW'(occ_w - 1'b1);
          store_req.wdata = car_r;
          tmp_req.wdata   = car_r;
          if (pass_r[0]) begin
            front_nxt = '0;
          end
          cnt_nxt = '0;
          if (pass_r == passes - 1'b1) begin
            state_nxt = S_RESP;
          end else begin
            pass_nxt = pass_r + 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_RDALL: begin
        store_req.raddr = slot(front_r, cnt_r);
        cnt_nxt         = cnt_r + 1'b1;
        state_nxt       = S_RDWAIT;
      end

      S_RDWAIT: begin
        res_val_nxt  = store_rdata;
        res_last_nxt = (cnt_r == occ_w);
        state_nxt    = S_RESP;
      end

      S_RESP: begin
        if (out_load) begin
          state_nxt = res_last_r ? S_IDLE : S_RDALL;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = res_val_r;
      out_st_nxt    = res_st_r;
      out_len_nxt   = occ_r;
      out_last_nxt  = res_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    cnt_r      <= cnt_nxt;
    pass_r     <= pass_nxt;
    car_r      <= car_nxt;
    ri_r       <= ri_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    res_last_r <= res_last_nxt;
    out_val_r  <= out_val_nxt;
    out_st_r   <= out_st_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= sde_pkg::DEPTH_L)
    else $error("occupancy above depth");

  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("accepted transaction left sequencer idle");

  a_idle_holds_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_fire) |=> $stable(occ_r) && $stable(front_r))
    else $error("state changed without a transaction");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_last_r) |=> state_r == S_IDLE && out_valid_r)
    else $error("final result did not end the request");

endmodule

>>> rtl/sortable_deque_engine.sv
// ----------------------------------------------------------------------------
// sortable_deque_engine
// Bounded deque of signed 32-bit values with delete, stable sort and read-out.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (valid/ready) with a request code and a value;
// results leave on out_ch (valid/ready), each with value, status, length and
// a last flag. One request is worked on at a time; in_ch.ready is high only
// while the sequencer is idle. Values live in a 16-entry synchronous RAM
// with a registered read port; a second RAM of the same size holds sort data.
// Delete searches then shifts; sort runs n or n+1 passes (even) over n values;
// read all gives 1 result per value, with last on the final one.
// The request rate is set by the single read and write port of the value RAM.
// Reset (rst_n low, synchronous) empties the deque and drops any pending
// result; RAM contents are not cleared and never read unwritten.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
module sortable_deque_engine (
  input  logic      clk,
  input  logic      rst_n,
  sde_req_if.sink   in_ch,
  sde_rsp_if.source out_ch
);

  sde_pkg::ram_req_t store_req;
  sde_pkg::ram_req_t tmp_req;
  sde_pkg::data_t    store_rdata;
  sde_pkg::data_t    tmp_rdata;

  sde_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .store_req   (store_req),
    .store_rdata (store_rdata),
    .tmp_req     (tmp_req),
    .tmp_rdata   (tmp_rdata)
  );

  sde_ram #(
    .DEPTH_P (sde_pkg::DEPTH),
    .WIDTH_P (sde_pkg::DATA_W),
    .AW_P    (sde_pkg::AW)
  ) u_store_ram (
    .clk   (clk),
    .we    (store_req.we),
    .waddr (store_req.waddr),
    .wdata (store_req.wdata),
    .raddr (store_req.raddr),
    .rdata (store_rdata)
  );

  sde_ram #(
    .DEPTH_P (sde_pkg::DEPTH),
    .WIDTH_P (sde_pkg::DATA_W),
    .AW_P    (sde_pkg::AW)
  ) u_tmp_ram (
    .clk   (clk),
    .we    (tmp_req.we),
    .waddr (tmp_req.waddr),
    .wdata (tmp_req.wdata),
    .raddr (tmp_req.raddr),
    .rdata (tmp_rdata)
  );

endmodule
